/* hdl/two_wire_display_frame_sender_macros.svh */
// assertion macros shared by the frame sender modules
`ifndef TWO_WIRE_DISPLAY_FRAME_SENDER_MACROS_SVH
`define TWO_WIRE_DISPLAY_FRAME_SENDER_MACROS_SVH

`ifndef ASSERT_OFF
`define TWDFS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TWDFS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TWDFS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TWDFS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hdl/twdfs_pkg.sv */
package twdfs_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam logic [3:0] ACK_INDEX = 4'd8;
  localparam logic [15:0] PHASE_CYCLES_RESET = 16'd250;

  localparam logic [1:0] START_LAST = 2'd2;
  localparam logic [1:0] BIT_LAST = 2'd2;
  localparam logic [1:0] STOP_LAST = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] address_byte;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic last_phase;
  } out_item_t;

  typedef struct packed {
    logic       two_bytes;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_BYTE,
    ST_STOP
  } state_t;

endpackage

/* hdl/twdfs_front.sv */
`include "two_wire_display_frame_sender_macros.svh"

module twdfs_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  twdfs_pkg::in_item_t in_item,
  output logic                job_valid,
  input  logic                job_pop,
  output twdfs_pkg::job_t     job
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  twdfs_pkg::job_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             push;
  twdfs_pkg::job_t  job_in;

  assign in_ready  = (count != CNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign job_valid = (count != '0);
  assign job       = mem[rd_ptr];

  // classify: a command is a one-byte frame
  always_comb begin
    job_in.two_bytes   = in_item.operation;
    job_in.first_byte  = in_item.operation ? in_item.address_byte : in_item.data_byte;
    job_in.second_byte = in_item.data_byte;
  end

  always_comb begin
    unique case ({push, job_pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (job_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  `TWDFS_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= CNT_W'(QUEUE_DEPTH))
  `TWDFS_ASSERT_IMPL(a_pop_nonempty, clk, rst, job_pop, count != '0)

endmodule

/* hdl/twdfs_back.sv */
`include "two_wire_display_frame_sender_macros.svh"

module twdfs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          phase_cycles,
  input  logic                 job_valid,
  output logic                 job_pop,
  input  twdfs_pkg::job_t      job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output twdfs_pkg::out_item_t out_item
);

  twdfs_pkg::state_t    state;
  twdfs_pkg::state_t    state_next;
  logic [1:0]           sub;
  logic [1:0]           sub_next;
  logic [3:0]           bit_idx;
  logic [3:0]           bit_idx_next;
  logic                 byte_sel;
  logic                 byte_sel_next;
  logic [15:0]          hold;
  logic                 dio_prev;
  twdfs_pkg::job_t      cur_job;
  twdfs_pkg::out_item_t phase;
  logic                 fire;
  logic                 slot_free;
  logic [7:0]           cur_byte;
  logic                 cur_bit;

  assign cur_byte = byte_sel ? cur_job.second_byte : cur_job.first_byte;
  assign cur_bit  = (bit_idx == twdfs_pkg::ACK_INDEX) ? 1'b1 : cur_byte[bit_idx[2:0]];

  // outputs
  always_comb begin
    slot_free = !out_valid || out_ready;
    fire      = (state != twdfs_pkg::ST_IDLE) && (hold == '0) && slot_free;
    job_pop   = (state == twdfs_pkg::ST_IDLE) && job_valid;
    phase     = '0;
    unique case (state)
      twdfs_pkg::ST_IDLE: begin
        phase = '0;
      end
      twdfs_pkg::ST_START: begin
        unique case (sub)
          2'd0:    phase = '{clk_level: 1'b1, dio_level: 1'b1, last_phase: 1'b0};
          2'd1:    phase = '{clk_level: 1'b1, dio_level: 1'b0, last_phase: 1'b0};
          default: phase = '{clk_level: 1'b0, dio_level: 1'b0, last_phase: 1'b0};
        endcase
      end
      twdfs_pkg::ST_BYTE: begin
        unique case (sub)
          2'd0:    phase = '{clk_level: 1'b0, dio_level: dio_prev, last_phase: 1'b0};
          2'd1:    phase = '{clk_level: 1'b0, dio_level: cur_bit, last_phase: 1'b0};
          default: phase = '{clk_level: 1'b1, dio_level: cur_bit, last_phase: 1'b0};
        endcase
      end
      twdfs_pkg::ST_STOP: begin
        unique case (sub)
          2'd0:    phase = '{clk_level: 1'b0, dio_level: dio_prev, last_phase: 1'b0};
          2'd1:    phase = '{clk_level: 1'b0, dio_level: 1'b0, last_phase: 1'b0};
          2'd2:    phase = '{clk_level: 1'b1, dio_level: 1'b0, last_phase: 1'b0};
          default: phase = '{clk_level: 1'b1, dio_level: 1'b1, last_phase: 1'b1};
        endcase
      end
      default: phase = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next    = state;
    sub_next      = sub;
    bit_idx_next  = bit_idx;
    byte_sel_next = byte_sel;
    if (job_pop) begin
      state_next    = twdfs_pkg::ST_START;
      sub_next      = '0;
      bit_idx_next  = '0;
      byte_sel_next = 1'b0;
    end else if (fire) begin
      unique case (state)
        twdfs_pkg::ST_START: begin
          if (sub == twdfs_pkg::START_LAST) begin
            state_next = twdfs_pkg::ST_BYTE;
            sub_next   = '0;
          end else begin
            sub_next = sub + 1'b1;
          end
        end
        twdfs_pkg::ST_BYTE: begin
          if (sub == twdfs_pkg::BIT_LAST) begin
            sub_next = '0;
            if (bit_idx == twdfs_pkg::ACK_INDEX) begin
              bit_idx_next = '0;
              if (cur_job.two_bytes && !byte_sel) begin
                byte_sel_next = 1'b1;
              end else begin
                state_next = twdfs_pkg::ST_STOP;
              end
            end else begin
              bit_idx_next = bit_idx + 1'b1;
            end
          end else begin
            sub_next = sub + 1'b1;
          end
        end
        twdfs_pkg::ST_STOP: begin
          if (sub == twdfs_pkg::STOP_LAST) begin
            state_next = twdfs_pkg::ST_IDLE;
            sub_next   = '0;
          end else begin
            sub_next = sub + 1'b1;
          end
        end
        default: state_next = twdfs_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_job <= job;
    end
    if (fire) begin
      out_item <= phase;
      dio_prev <= phase.dio_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= twdfs_pkg::ST_IDLE;
      sub       <= '0;
      bit_idx   <= '0;
      byte_sel  <= 1'b0;
      hold      <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      sub      <= sub_next;
      bit_idx  <= bit_idx_next;
      byte_sel <= byte_sel_next;
      if (fire) begin
        hold <= phase_cycles;
      end else if (hold != '0) begin
        hold <= hold - 1'b1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TWDFS_ASSERT_IMPL(a_last_idle_lines, clk, rst, out_valid && out_item.last_phase, out_item.clk_level && out_item.dio_level)
  `TWDFS_ASSERT_IMPL(a_bit_range, clk, rst, state == twdfs_pkg::ST_BYTE, bit_idx <= twdfs_pkg::ACK_INDEX)
  `TWDFS_ASSERT_NEXT(a_hold_loaded, clk, rst, fire, hold == $past(phase_cycles))

endmodule

/* hdl/two_wire_display_frame_sender.sv */
// Sends one write per input item as line phases of a two-wire display link: a command item
// gives 34 phases, an address-plus-data item 61, each an output item with the clock and data
// levels and a flag on the final stop phase. A hold counter paces the phases: when one is
// issued the counter is loaded with phase_cycles, and the next follows once it has counted
// down to zero (every clock when phase_cycles is 0), and later if the output is stalled; a
// frame is taken from the queue in the idle state before its first phase, which overlaps the
// previous frame's last hold if that still runs. phase_cycles resets to 250. A queue of
// QUEUE_DEPTH items takes new writes while a frame is sent.
module two_wire_display_frame_sender #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  twdfs_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output twdfs_pkg::out_item_t out_item
);

  logic [15:0]     phase_cycles;
  logic            job_valid;
  logic            job_pop;
  twdfs_pkg::job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_cycles <= twdfs_pkg::PHASE_CYCLES_RESET;
    end else if (cfg_write) begin
      phase_cycles <= cfg_data;
    end
  end

  twdfs_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  twdfs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .phase_cycles (phase_cycles),
    .job_valid    (job_valid),
    .job_pop      (job_pop),
    .job          (job),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item)
  );

endmodule
